/* hw/rtl/doorway_passenger_counter_unit_defines.svh */
// Assertion macros shared by the doorway passenger counter RTL.
`ifndef DOORWAY_PASSENGER_COUNTER_UNIT_DEFINES_SVH
`define DOORWAY_PASSENGER_COUNTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DPC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/doorpc_pkg.sv */
// Types, constants and helpers for the doorway passenger counter.
package doorpc_pkg;

  localparam int COORD_BITS  = 10;
  localparam int COUNT_BITS  = 20;
  localparam int DARK_BITS   = 20;
  localparam int SWING_BITS  = 20;
  localparam int NET_BITS    = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] LOW_MARK_RST  = COUNT_BITS'(1500);
  localparam logic [COUNT_BITS-1:0] HIGH_MARK_RST = COUNT_BITS'(2000);

  localparam logic [7:0]            DARK_THR_RST  = 8'd75;
  localparam logic [SWING_BITS-1:0] SWING_RST     = SWING_BITS'(2500);
  localparam logic [COORD_BITS-1:0] ROI_X_RST     = COORD_BITS'(100);
  localparam logic [COORD_BITS-1:0] ROI_Y_RST     = COORD_BITS'(190);
  localparam logic [COORD_BITS-1:0] ROI_W_RST     = COORD_BITS'(440);
  localparam logic [COORD_BITS-1:0] ROI_H_RST     = COORD_BITS'(100);
  localparam logic [7:0]            BAND_RST      = 8'd10;
  localparam logic [7:0]            WARMUP_RST    = 8'd11;

  localparam int CFG_IDX_BITS = 4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DARK_THR = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SWING    = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROI_X    = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROI_Y    = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROI_W    = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROI_H    = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BAND     = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WARMUP   = 4'd7;
  localparam int CFG_DATA_BITS = 20;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_IN   = 2'd1;
  localparam logic [1:0] EV_OUT  = 2'd2;
  localparam logic [1:0] EV_WARM = 2'd3;

  typedef struct packed {
    logic [7:0]            pixel;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  frame_end;
  } pix_in_t;

  typedef struct packed {
    logic signed [NET_BITS-1:0] passenger_count;
    logic [1:0]                 event_res;
    logic [DARK_BITS-1:0]       dark_pixels;
    logic                       occupied;
  } result_t;

  typedef struct packed {
    logic [7:0]            dark_thr;
    logic [SWING_BITS-1:0] swing;
    logic [COORD_BITS-1:0] roi_x;
    logic [COORD_BITS-1:0] roi_y;
    logic [COORD_BITS-1:0] roi_w;
    logic [COORD_BITS-1:0] roi_h;
    logic [7:0]            band;
    logic [7:0]            warmup;
  } cfg_t;

  typedef struct packed {
    logic dark;
    logic top;
    logic bot;
    logic frame_end;
  } cls_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

/* hw/rtl/doorpc_front.sv */
// Front end: takes pixel beats and classifies them against the counting region.
module doorpc_front import doorpc_pkg::*; (
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  pix_in_t in_data,
  input  logic    q_full,
  output logic    q_push,
  output cls_t    q_data
);

  localparam int SW = COORD_BITS + 1;

  logic [SW-1:0] col_w, row_w, band_w, x_end, y_end, top_lim;
  logic          in_x, in_y, dark;

  always_comb begin
    col_w   = {1'b0, in_data.col};
    row_w   = {1'b0, in_data.row};
    band_w  = SW'(cfg.band);
    x_end   = {1'b0, cfg.roi_x} + {1'b0, cfg.roi_w};
    y_end   = {1'b0, cfg.roi_y} + {1'b0, cfg.roi_h};
    top_lim = {1'b0, cfg.roi_y} + band_w;
    in_x    = (in_data.col >= cfg.roi_x) && (col_w < x_end);
    in_y    = (in_data.row >= cfg.roi_y) && (row_w < y_end);
    dark    = in_x && in_y && (in_data.pixel <= cfg.dark_thr);
    q_data.dark      = dark;
    q_data.top       = dark && (row_w < top_lim);
    q_data.bot       = dark && ((row_w + band_w) >= y_end);
    q_data.frame_end = in_data.frame_end;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

/* hw/rtl/doorpc_fifo.sv */
// Short queue of classified pixel beats between front and back end.
`include "doorway_passenger_counter_unit_defines.svh"
module doorpc_fifo import doorpc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cls_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cls_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  `DPC_ASSERT_NOW(a_q_bound, 1'b1, count_r <= FULL_CNT, "queue count beyond depth")
  `DPC_ASSERT_NOW(a_q_push_room, push, !full, "push into full queue")
  `DPC_ASSERT_NOW(a_q_pop_data, pop, not_empty, "pop from empty queue")
  `DPC_ASSERT_NEXT(a_q_drain, pop && !push, count_r == $past(count_r) - 1'b1, "queue count lost a pop")

endmodule

/* hw/rtl/doorpc_back.sv */
// Back end: accumulates frame counts and runs the valley/peak tracker at frame end.
`include "doorway_passenger_counter_unit_defines.svh"
module doorpc_back import doorpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  cls_t    q_data,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int DW   = COUNT_BITS + 2;
  localparam int SUMW = COUNT_BITS + 3;
  localparam logic signed [NET_BITS-1:0] NET_MAX = {1'b0, {(NET_BITS-1){1'b1}}};
  localparam logic signed [NET_BITS-1:0] NET_MIN = {1'b1, {(NET_BITS-1){1'b0}}};

  logic [COUNT_BITS-1:0] dark_r, dark_nxt, top_r, top_nxt, bot_r, bot_nxt;
  logic [COUNT_BITS-1:0] dark_inc, top_inc, bot_inc;
  logic [COUNT_BITS-1:0] fr_dark_r, fr_top_r, fr_bot_r;
  logic                  fe_r, fe_nxt;

  logic [7:0]                  frames_r, frames_nxt;
  logic                        primed_r, primed_nxt;
  logic [COUNT_BITS-1:0]       prev_r, prev_nxt, low_r, low_nxt, high_r, high_nxt;
  logic                        rising_r, rising_nxt, inside_r, inside_nxt;
  logic signed [COUNT_BITS:0]  st_r, st_nxt, sb_r, sb_nxt;
  logic signed [NET_BITS-1:0]  net_r, net_nxt, net_inc, net_dec;
  logic                        out_valid_r, out_valid_nxt;
  result_t                     out_data_r, out_data_nxt;

  logic                        b_go, warm, up, enter, leave, inside_mid, dir_in;
  logic [DW-1:0]               lo_diff, hi_diff, swing_ext;
  logic signed [SUMW-1:0]      dir_sum;
  logic signed [COUNT_BITS:0]  top_s, bot_s;
  logic [1:0]                  ev;

  assign b_go  = !out_valid_r || out_ready;
  assign q_pop = q_valid && (!fe_r || b_go);

  always_comb begin
    dark_inc = q_data.dark ? sat_inc(dark_r) : dark_r;
    top_inc  = q_data.top ? sat_inc(top_r) : top_r;
    bot_inc  = q_data.bot ? sat_inc(bot_r) : bot_r;
    dark_nxt = dark_r;
    top_nxt  = top_r;
    bot_nxt  = bot_r;
    fe_nxt   = fe_r && !b_go;
    if (q_pop) begin
      fe_nxt = q_data.frame_end;
      if (q_data.frame_end) begin
        dark_nxt = '0;
        top_nxt  = '0;
        bot_nxt  = '0;
      end else begin
        dark_nxt = dark_inc;
        top_nxt  = top_inc;
        bot_nxt  = bot_inc;
      end
    end
  end

  always_comb begin
    warm       = frames_r < cfg.warmup;
    up         = fr_dark_r >= prev_r;
    swing_ext  = DW'(cfg.swing);
    lo_diff    = {2'b00, fr_dark_r} - {2'b00, low_r};
    hi_diff    = {2'b00, high_r} - {2'b00, fr_dark_r};
    enter      = primed_r && !inside_r && up && ($signed(lo_diff) > $signed(swing_ext));
    leave      = inside_r && ($signed(hi_diff) > $signed(swing_ext));
    inside_mid = inside_r || enter;
    top_s      = $signed({1'b0, fr_top_r});
    bot_s      = $signed({1'b0, fr_bot_r});
    dir_sum    = SUMW'(st_r) - SUMW'(top_s) + SUMW'(bot_s) - SUMW'(sb_r);
    dir_in     = dir_sum[SUMW-1];
    net_inc    = (net_r != NET_MAX) ? net_r + 1'b1 : net_r;
    net_dec    = (net_r != NET_MIN) ? net_r - 1'b1 : net_r;

    frames_nxt    = frames_r;
    primed_nxt    = primed_r;
    prev_nxt      = prev_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    rising_nxt    = rising_r;
    inside_nxt    = inside_r;
    st_nxt        = st_r;
    sb_nxt        = sb_r;
    net_nxt       = net_r;
    ev            = EV_NONE;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    if (fe_r && b_go) begin
      if (warm) begin
        frames_nxt = frames_r + 1'b1;
        ev         = EV_WARM;
      end else begin
        primed_nxt = 1'b1;
        prev_nxt   = fr_dark_r;
        rising_nxt = up;
        if (!primed_r || (!rising_r && up &&
            ((!inside_r && (fr_dark_r < low_r)) || inside_mid))) begin
          low_nxt = fr_dark_r;
        end
        if (!primed_r || enter ||
            (inside_mid && rising_r && !up && (fr_dark_r > high_r))) begin
          high_nxt = fr_dark_r;
        end
        if (enter) begin
          inside_nxt = 1'b1;
          st_nxt     = top_s;
          sb_nxt     = bot_s;
        end
        if (leave) begin
          inside_nxt = 1'b0;
          st_nxt     = st_r - top_s;
          sb_nxt     = bot_s - sb_r;
          if (dir_in) begin
            net_nxt = net_inc;
            ev      = EV_IN;
          end else begin
            net_nxt = net_dec;
            ev      = EV_OUT;
          end
        end
      end
      out_valid_nxt                = 1'b1;
      out_data_nxt.passenger_count = net_nxt;
      out_data_nxt.event_res       = ev;
      out_data_nxt.dark_pixels     = DARK_BITS'(fr_dark_r);
      out_data_nxt.occupied        = inside_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r      <= '0;
      top_r       <= '0;
      bot_r       <= '0;
      fe_r        <= 1'b0;
      frames_r    <= '0;
      primed_r    <= 1'b0;
      prev_r      <= '0;
      low_r       <= LOW_MARK_RST;
      high_r      <= HIGH_MARK_RST;
      rising_r    <= 1'b0;
      inside_r    <= 1'b0;
      st_r        <= '0;
      sb_r        <= '0;
      net_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dark_r      <= dark_nxt;
      top_r       <= top_nxt;
      bot_r       <= bot_nxt;
      fe_r        <= fe_nxt;
      frames_r    <= frames_nxt;
      primed_r    <= primed_nxt;
      prev_r      <= prev_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      rising_r    <= rising_nxt;
      inside_r    <= inside_nxt;
      st_r        <= st_nxt;
      sb_r        <= sb_nxt;
      net_r       <= net_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (q_pop && q_data.frame_end) begin
      fr_dark_r <= dark_inc;
      fr_top_r  <= top_inc;
      fr_bot_r  <= bot_inc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DPC_ASSERT_NEXT(a_fe_hold, fe_r && !b_go, fe_r, "frame end dropped while output stalled")
  `DPC_ASSERT_NOW(a_one_edge, fe_r && b_go, !(enter && leave), "enter and leave in one frame")
  `DPC_ASSERT_NEXT(a_leave_res, fe_r && b_go && !warm && leave, out_valid_r && !out_data_r.occupied && (out_data_r.event_res == EV_IN || out_data_r.event_res == EV_OUT), "leave without direction result")

endmodule

/* hw/rtl/doorway_passenger_counter_unit.sv */
// Top level of the doorway passenger counter: config registers, front, queue, back.
//
//   channel  | ports                                      | beat
//   ---------+--------------------------------------------+------------------------------
//   in       | in_valid, in_ready, in_data                | one pixel with col, row, end
//   out      | out_valid, out_ready, out_data             | one result per frame end
//   cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data  | one register write
//
// Sustains one pixel beat per cycle while the queue is not full; the region compare in
// the front end is combinational and the back end counts each beat as it is popped.
// A frame-end result passes the queue, the back end's frame registers, then the tracker.
// Reset is synchronous; config returns to its defaults, no clearing pass.
// The four-entry queue absorbs output stalls; in_ready drops only when it is full.
// cfg_ready is always high; indexes beyond the register list are dropped.
module doorway_passenger_counter_unit import doorpc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pix_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output result_t                  out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_push, q_pop, q_valid;
  cls_t q_in, q_out;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DARK_THR: cfg_nxt.dark_thr = cfg_data[7:0];
        CFG_SWING:    cfg_nxt.swing    = cfg_data[SWING_BITS-1:0];
        CFG_ROI_X:    cfg_nxt.roi_x    = cfg_data[COORD_BITS-1:0];
        CFG_ROI_Y:    cfg_nxt.roi_y    = cfg_data[COORD_BITS-1:0];
        CFG_ROI_W:    cfg_nxt.roi_w    = cfg_data[COORD_BITS-1:0];
        CFG_ROI_H:    cfg_nxt.roi_h    = cfg_data[COORD_BITS-1:0];
        CFG_BAND:     cfg_nxt.band     = cfg_data[7:0];
        CFG_WARMUP:   cfg_nxt.warmup   = cfg_data[7:0];
        default:      cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_thr <= DARK_THR_RST;
      cfg_r.swing    <= SWING_RST;
      cfg_r.roi_x    <= ROI_X_RST;
      cfg_r.roi_y    <= ROI_Y_RST;
      cfg_r.roi_w    <= ROI_W_RST;
      cfg_r.roi_h    <= ROI_H_RST;
      cfg_r.band     <= BAND_RST;
      cfg_r.warmup   <= WARMUP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  doorpc_front u_front (
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  doorpc_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  doorpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
